// ===== rtl/core/mhft_pkg.sv =====
// Types, codes and byte classification shared by the header field tokenizer.
package mhft_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_field;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  token_type;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_result;
	} out_item_t;

	localparam int RES_MAX = 3;

	typedef struct packed {
		logic [1:0]                count;
		out_item_t [RES_MAX-1:0]   res;
	} bundle_t;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ATOM    = 3'd1;
	localparam logic [2:0] PH_QUOTED  = 3'd2;
	localparam logic [2:0] PH_COMMENT = 3'd3;
	localparam logic [2:0] PH_DOMAIN  = 3'd4;

	localparam logic [3:0] TK_ERROR    = 4'd0;
	localparam logic [3:0] TK_NULL     = 4'd1;
	localparam logic [3:0] TK_SPECIAL  = 4'd2;
	localparam logic [3:0] TK_ATOM     = 4'd3;
	localparam logic [3:0] TK_COMMENT  = 4'd4;
	localparam logic [3:0] TK_QUOTED   = 4'd5;
	localparam logic [3:0] TK_DOMAIN   = 4'd6;
	localparam logic [3:0] TK_TSPECIAL = 4'd7;
	localparam logic [3:0] TK_TOKEN    = 4'd8;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DLE    = 8'h10;
	localparam logic [7:0] CH_CTL_MAX = 8'h1F;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c <= CH_CTL_MAX) && (c != CH_DLE));
	endfunction

	function automatic logic is_special(input logic [7:0] c, input logic mode);
		logic r;
		unique case (c) inside
			CH_RPAREN, CH_LT, CH_GT, CH_AT, CH_COMMA,
			CH_SEMI, CH_COLON, CH_BSLASH, CH_RBRACK: r = 1'b1;
			CH_PERIOD:                               r = !mode;
			CH_SLASH, CH_QMARK, CH_EQUALS:           r = mode;
			default:                                 r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/mhft_lexer.sv =====
// Lexer state registers and the combinational next-state and token logic.
module mhft_lexer #(
	parameter int FIELD_LEN_MAX = 65535,
	parameter int NEST_MAX      = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mhft_pkg::in_item_t in_item,
	input  logic              mode,
	output mhft_pkg::bundle_t bundle
);
	import mhft_pkg::*;

	localparam int POS_CAP_I   = (FIELD_LEN_MAX < 65535) ? FIELD_LEN_MAX : 65535;
	localparam int DEPTH_CAP_I = (NEST_MAX < 255) ? NEST_MAX : 255;
	localparam logic [15:0] POS_CAP   = 16'(POS_CAP_I);
	localparam logic [7:0]  DEPTH_CAP = 8'(DEPTH_CAP_I);

	logic [2:0]  phase_q;
	logic        esc_q;
	logic [7:0]  depth_q;
	logic [15:0] tstart_q;
	logic [15:0] pos_q;

	logic [2:0]  phase_d;
	logic        esc_d;
	logic [7:0]  depth_d;
	logic [15:0] tstart_d;
	logic [15:0] pos_d;

	always_comb begin
		logic [7:0]  c;
		logic [1:0]  n;
		logic        do_start;
		logic [16:0] len1;
		logic [3:0]  atom_type;
		out_item_t   res [RES_MAX];

		c         = in_item.data_byte;
		n         = 2'd0;
		do_start  = 1'b0;
		phase_d   = phase_q;
		esc_d     = esc_q;
		depth_d   = depth_q;
		tstart_d  = tstart_q;
		pos_d     = pos_q;
		atom_type = mode ? TK_TOKEN : TK_ATOM;
		len1      = {1'b0, pos_q} + 17'd1 - {1'b0, tstart_q};
		for (int i = 0; i < RES_MAX; i++) begin
			res[i] = '0;
		end

		if (in_item.byte_valid) begin
			unique case (phase_q) inside
				PH_ATOM: begin
					if (is_blank(c) || c == CH_DQUOTE || c == CH_LPAREN ||
					    c == CH_LBRACK || is_special(c, mode)) begin
						res[n] = '{atom_type, tstart_q, pos_q - tstart_q, 1'b0};
						n = n + 2'd1;
						phase_d  = PH_IDLE;
						do_start = 1'b1;
					end
				end
				PH_QUOTED, PH_DOMAIN: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == ((phase_q == PH_QUOTED) ? CH_DQUOTE : CH_RBRACK)) begin
						res[n] = '{(phase_q == PH_QUOTED) ? TK_QUOTED : TK_DOMAIN, tstart_q,
						           len1[16] ? 16'hFFFF : len1[15:0], 1'b0};
						n = n + 2'd1;
						phase_d = PH_IDLE;
					end
				end
				PH_COMMENT: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == CH_RPAREN) begin
						if (depth_q != 8'd0) begin
							depth_d = depth_q - 8'd1;
						end
						if (depth_d == 8'd0) begin
							res[n] = '{TK_COMMENT, tstart_q,
							           len1[16] ? 16'hFFFF : len1[15:0], 1'b0};
							n = n + 2'd1;
							phase_d = PH_IDLE;
						end
					end else if (c == CH_LPAREN) begin
						if (depth_q < DEPTH_CAP) begin
							depth_d = depth_q + 8'd1;
						end
					end
				end
				default: begin
					phase_d  = PH_IDLE;
					do_start = 1'b1;
				end
			endcase

			if (do_start && !is_blank(c)) begin
				tstart_d = pos_q;
				esc_d    = 1'b0;
				if (c == CH_DQUOTE) begin
					phase_d = PH_QUOTED;
				end else if (c == CH_LPAREN) begin
					phase_d = PH_COMMENT;
					depth_d = 8'd1;
				end else if (c == CH_LBRACK) begin
					phase_d = PH_DOMAIN;
				end else if (is_special(c, mode)) begin
					res[n] = '{mode ? TK_TSPECIAL : TK_SPECIAL, pos_q, 16'd1, 1'b0};
					n = n + 2'd1;
				end else begin
					phase_d = PH_ATOM;
				end
			end

			pos_d = (pos_q < POS_CAP) ? pos_q + 16'd1 : POS_CAP;
		end

		if (in_item.end_of_field) begin
			if (phase_d == PH_ATOM) begin
				res[n] = '{atom_type, tstart_d, pos_d - tstart_d, 1'b0};
				n = n + 2'd1;
			end else if (phase_d == PH_QUOTED || phase_d == PH_COMMENT ||
			             phase_d == PH_DOMAIN) begin
				res[n] = '{TK_ERROR, tstart_d, 16'd0, 1'b0};
				n = n + 2'd1;
			end
			res[n] = '{TK_NULL, pos_d, 16'd0, 1'b0};
			n = n + 2'd1;
			phase_d  = PH_IDLE;
			esc_d    = 1'b0;
			depth_d  = 8'd0;
			tstart_d = 16'd0;
			pos_d    = 16'd0;
		end

		for (int i = 0; i < RES_MAX; i++) begin
			res[i].last_result = (n != 2'd0) && (2'(i) == n - 2'd1);
			bundle.res[i]      = res[i];
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			esc_q    <= 1'b0;
			depth_q  <= 8'd0;
			tstart_q <= 16'd0;
			pos_q    <= 16'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			esc_q    <= esc_d;
			depth_q  <= depth_d;
			tstart_q <= tstart_d;
			pos_q    <= pos_d;
		end
	end

endmodule

// ===== rtl/core/mhft_emit.sv =====
// Result register that holds the tokens of one item and hands them out one per cycle while out_stall is low.
module mhft_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mhft_pkg::bundle_t   bundle,
	output logic                free,
	output logic                out_valid,
	input  logic                out_stall,
	output mhft_pkg::out_item_t out_item
);
	import mhft_pkg::*;

	logic                    busy_q;
	logic [1:0]              cnt_q;
	logic [1:0]              rd_q;
	out_item_t [RES_MAX-1:0] res_q;

	logic out_acc;
	logic drain_done;

	assign out_valid  = busy_q;
	assign out_item   = res_q[rd_q];
	assign out_acc    = busy_q && !out_stall;
	assign drain_done = out_acc && (rd_q == cnt_q - 2'd1);
	assign free       = !busy_q || drain_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			rd_q   <= 2'd0;
		end else if (load && bundle.count != 2'd0) begin
			busy_q <= 1'b1;
			cnt_q  <= bundle.count;
			rd_q   <= 2'd0;
		end else if (drain_done) begin
			busy_q <= 1'b0;
			rd_q   <= 2'd0;
		end else if (out_acc) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && bundle.count != 2'd0) begin
			res_q <= bundle.res;
		end
	end

endmodule

// ===== rtl/core/mail_header_field_tokenizer.sv =====
// Top level of the mail header field tokenizer: mode register, lexer and result register.
// Latency: the first token of an item is offered in the cycle after the item is accepted.
// Throughput: one item per cycle while items give at most one token and out_stall is low;
// else input waits until its last token is taken, as the result port carries one a cycle.
// Reset clears lexer state, the mode register (RFC 822 mode) and the result valid and count.
module mail_header_field_tokenizer #(
	parameter int FIELD_LEN_MAX = 65535,
	parameter int NEST_MAX      = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mhft_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mhft_pkg::out_item_t out_item,
	input  logic                mode_we,
	input  logic                mode_wdata
);
	import mhft_pkg::*;

	logic    mode_q;
	logic    free;
	logic    in_acc;
	bundle_t bundle;

	assign in_stall = !free;
	assign in_acc   = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	mhft_lexer #(
		.FIELD_LEN_MAX(FIELD_LEN_MAX),
		.NEST_MAX     (NEST_MAX)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_acc),
		.in_item(in_item),
		.mode   (mode_q),
		.bundle (bundle)
	);

	mhft_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_acc),
		.bundle   (bundle),
		.free     (free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	a_eof_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.end_of_field |=> out_valid)
		else $error("end of field gave no token");

	a_null_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.token_type == TK_NULL |-> out_item.last_result)
		else $error("null token not marked last");

	a_error_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.token_type == TK_ERROR |-> out_item.token_length == 16'd0)
		else $error("error token with nonzero length");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the mail header field tokenizer.
`timescale 1ns / 100ps

module testbench;
	import mhft_pkg::*;

	localparam int FIELD_LEN_MAX = 65535;
	localparam int NEST_MAX      = 255;
	localparam int POS_CAP       = (FIELD_LEN_MAX < 65535) ? FIELD_LEN_MAX : 65535;
	localparam int DEPTH_CAP     = (NEST_MAX < 255) ? NEST_MAX : 255;
	localparam int RANDOM_ITEMS  = 180;
	localparam int LIMIT         = 50000000;

	typedef struct {
		logic      mode;
		in_item_t  item;
		bit        typed;
		out_item_t tok;
	} vector_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      mode_we;
	logic      mode_wdata;

	// Token predictor state.
	logic       mode_q;
	logic [2:0] phase;
	bit         esc;
	int         depth;
	int         tok_start;
	int         pos;

	out_item_t  expected_tokens[$];
	vector_t    directed[$];
	logic [7:0] field_bytes[$];
	out_item_t  want;
	int         last_count;
	int         items_sent;
	int         mismatches;
	int         stall_left;
	int unsigned cycles = 0;
	bit         calm;

	mail_header_field_tokenizer #(
		.FIELD_LEN_MAX(FIELD_LEN_MAX),
		.NEST_MAX(NEST_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.mode_we(mode_we),
		.mode_wdata(mode_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit blank_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c < 8'd32 && c != CH_DLE);
	endfunction

	function automatic bit special_byte(input logic [7:0] c, input logic m);
		bit shared;
		shared = (c == CH_RPAREN) || (c == CH_LT) || (c == CH_GT) || (c == CH_AT) ||
			(c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) || (c == CH_BSLASH) ||
			(c == CH_RBRACK);
		if (m)
			return shared || c == CH_SLASH || c == CH_QMARK || c == CH_EQUALS;
		return shared || c == CH_PERIOD;
	endfunction

	function automatic bit closes_atom(input logic [7:0] c);
		return blank_byte(c) || c == CH_DQUOTE || c == CH_LPAREN || c == CH_LBRACK ||
			special_byte(c, mode_q);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 32)); while (b == CH_DLE);
		return b;
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 12))
			0:       return CH_RPAREN;
			1:       return CH_LT;
			2:       return CH_GT;
			3:       return CH_AT;
			4:       return CH_COMMA;
			5:       return CH_SEMI;
			6:       return CH_COLON;
			7:       return CH_BSLASH;
			8:       return CH_RBRACK;
			9:       return CH_PERIOD;
			10:      return CH_SLASH;
			11:      return CH_QMARK;
			default: return CH_EQUALS;
		endcase
	endfunction

	task automatic add_token(input logic [3:0] kind, input int start, input int len);
		out_item_t t;
		t.token_type   = kind;
		t.token_start  = start[15:0];
		t.token_length = (len > 65535) ? 16'hFFFF : len[15:0];
		t.last_result  = 1'b0;
		expected_tokens.push_back(t);
	endtask

	task automatic open_token(input logic [7:0] c, input int p);
		if (!blank_byte(c)) begin
			tok_start = p;
			esc = 1'b0;
			if (c == CH_DQUOTE) begin
				phase = PH_QUOTED;
			end else if (c == CH_LPAREN) begin
				phase = PH_COMMENT;
				depth = 1;
			end else if (c == CH_LBRACK) begin
				phase = PH_DOMAIN;
			end else if (special_byte(c, mode_q)) begin
				add_token(mode_q ? TK_TSPECIAL : TK_SPECIAL, p, 1);
			end else begin
				phase = PH_ATOM;
			end
		end
	endtask

	// Works out the tokens that one accepted item gives and queues them.
	task automatic lex_item(input in_item_t it);
		logic [7:0] c;
		int first;
		int span;
		first = expected_tokens.size();
		c = it.data_byte;
		if (it.byte_valid) begin
			span = pos + 1 - tok_start;
			case (phase) inside
				PH_ATOM: begin
					if (closes_atom(c)) begin
						add_token(mode_q ? TK_TOKEN : TK_ATOM, tok_start, pos - tok_start);
						phase = PH_IDLE;
						open_token(c, pos);
					end
				end
				PH_QUOTED, PH_DOMAIN: begin
					if (esc) begin
						esc = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc = 1'b1;
					end else if (c == ((phase == PH_QUOTED) ? CH_DQUOTE : CH_RBRACK)) begin
						add_token((phase == PH_QUOTED) ? TK_QUOTED : TK_DOMAIN, tok_start, span);
						phase = PH_IDLE;
					end
				end
				PH_COMMENT: begin
					if (esc) begin
						esc = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc = 1'b1;
					end else if (c == CH_RPAREN) begin
						if (depth > 0)
							depth--;
						if (depth == 0) begin
							add_token(TK_COMMENT, tok_start, span);
							phase = PH_IDLE;
						end
					end else if (c == CH_LPAREN && depth < DEPTH_CAP) begin
						depth++;
					end
				end
				default: begin
					phase = PH_IDLE;
					open_token(c, pos);
				end
			endcase
			if (pos < POS_CAP)
				pos++;
		end
		if (it.end_of_field) begin
			if (phase == PH_ATOM)
				add_token(mode_q ? TK_TOKEN : TK_ATOM, tok_start, pos - tok_start);
			else if (phase != PH_IDLE)
				add_token(TK_ERROR, tok_start, 0);
			add_token(TK_NULL, pos, 0);
			phase = PH_IDLE;
			esc = 1'b0;
			depth = 0;
			tok_start = 0;
			pos = 0;
		end
		last_count = expected_tokens.size() - first;
		if (last_count > 0)
			expected_tokens[expected_tokens.size() - 1].last_result = 1'b1;
	endtask

	task automatic send_item(input in_item_t it, input bit rush);
		int gap;
		gap = rush ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		if (it.byte_valid || it.end_of_field)
			items_sent++;
		lex_item(it);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit eof, input bit rush);
		in_item_t it;
		it.data_byte    = b;
		it.byte_valid   = 1'b1;
		it.end_of_field = eof;
		send_item(it, rush);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(negedge clk);
		mode_we <= 1'b0;
		mode_q = m;
	endtask

	task automatic row(input logic m, input logic [7:0] b, input logic v, input logic e);
		vector_t r;
		r.mode = m;
		r.item.data_byte = b;
		r.item.byte_valid = v;
		r.item.end_of_field = e;
		r.typed = 1'b0;
		r.tok = '0;
		directed.push_back(r);
	endtask

	task automatic row_typed(input logic m, input logic [7:0] b, input logic v, input logic e,
			input logic [3:0] kind, input int start, input int len);
		vector_t r;
		r.mode = m;
		r.item.data_byte = b;
		r.item.byte_valid = v;
		r.item.end_of_field = e;
		r.typed = 1'b1;
		r.tok.token_type = kind;
		r.tok.token_start = start[15:0];
		r.tok.token_length = len[15:0];
		r.tok.last_result = 1'b1;
		directed.push_back(r);
	endtask

	task automatic wrap_bytes(input logic [7:0] opener, input logic [7:0] closer);
		logic [7:0] b;
		field_bytes.push_back(opener);
		repeat ($urandom_range(0, 4)) begin
			b = 8'($urandom_range(0, 255));
			if (b == closer || b == CH_BSLASH || (opener == CH_LPAREN && b == CH_LPAREN))
				field_bytes.push_back(CH_BSLASH);
			field_bytes.push_back(b);
		end
		if (opener == CH_LPAREN && $urandom_range(0, 2) == 0) begin
			field_bytes.push_back(CH_LPAREN);
			field_bytes.push_back(8'h7A);
			field_bytes.push_back(CH_RPAREN);
		end
		field_bytes.push_back(closer);
	endtask

	// Mostly well-formed field bodies, with some noise and an open construct now and then.
	task automatic build_field();
		logic [7:0] b;
		field_bytes.delete();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9)) inside
				0, 1: begin
					repeat ($urandom_range(1, 4)) begin
						do b = 8'($urandom_range(0, 255)); while (closes_atom(b));
						field_bytes.push_back(b);
					end
				end
				2:       field_bytes.push_back(pick_special());
				3:       wrap_bytes(CH_DQUOTE, CH_DQUOTE);
				4:       wrap_bytes(CH_LPAREN, CH_RPAREN);
				5:       wrap_bytes(CH_LBRACK, CH_RBRACK);
				6, 7:    field_bytes.push_back(pick_blank());
				default: field_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 2))
				0:       field_bytes.push_back(CH_DQUOTE);
				1:       field_bytes.push_back(CH_LPAREN);
				default: field_bytes.push_back(CH_LBRACK);
			endcase
			if ($urandom_range(0, 1) == 0)
				field_bytes.push_back(CH_BSLASH);
		end
	endtask

	task automatic send_field();
		in_item_t it;
		bit split;
		split = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < field_bytes.size(); i++) begin
			if ($urandom_range(0, 11) == 0) begin
				it.data_byte = 8'($urandom_range(0, 255));
				it.byte_valid = 1'b0;
				it.end_of_field = 1'b0;
				send_item(it, 1'b0);
			end
			send_byte(field_bytes[i], !split && i == field_bytes.size() - 1, 1'b0);
		end
		if (split) begin
			it.data_byte = 8'($urandom_range(0, 255));
			it.byte_valid = 1'b0;
			it.end_of_field = 1'b1;
			send_item(it, 1'b0);
		end
	endtask

	task automatic report(input string why, input out_item_t exp_tok);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
				why, exp_tok.token_type, exp_tok.token_start, exp_tok.token_length,
				exp_tok.last_result, out_item.token_type, out_item.token_start,
				out_item.token_length, out_item.last_result);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				report("unexpected token", '0);
			end else begin
				want = expected_tokens.pop_front();
				if (out_item.token_type !== want.token_type ||
						out_item.token_start !== want.token_start ||
						out_item.token_length !== want.token_length ||
						out_item.last_result !== want.last_result)
					report("token mismatch", want);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(40, 250)) @(posedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		@(negedge clk);
		forever begin
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
			@(negedge clk);
		end
	end

	initial begin
		vector_t v;
		in_item_t it;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		mode_we = 1'b0;
		mode_wdata = 1'b0;
		mismatches = 0;
		items_sent = 0;
		mode_q = 1'b0;
		phase = PH_IDLE;
		esc = 1'b0;
		depth = 0;
		tok_start = 0;
		pos = 0;

		row_typed(1'b0, 8'h00, 1'b0, 1'b1, TK_NULL, 0, 0);
		row(1'b0, 8'hFF, 1'b0, 1'b0);
		row_typed(1'b0, CH_AT, 1'b1, 1'b0, TK_SPECIAL, 0, 1);
		row(1'b0, 8'h61, 1'b1, 1'b0);
		row(1'b0, CH_DLE, 1'b1, 1'b0);
		row(1'b0, 8'h7F, 1'b1, 1'b0);
		row(1'b0, 8'hFF, 1'b1, 1'b0);
		row(1'b0, CH_PERIOD, 1'b1, 1'b0);
		row(1'b0, 8'h00, 1'b1, 1'b0);
		row(1'b0, CH_CTL_MAX, 1'b1, 1'b0);
		row(1'b0, CH_DQUOTE, 1'b1, 1'b0);
		row(1'b0, CH_BSLASH, 1'b1, 1'b0);
		row(1'b0, CH_DQUOTE, 1'b1, 1'b0);
		row(1'b0, CH_DQUOTE, 1'b1, 1'b0);
		row(1'b0, CH_LBRACK, 1'b1, 1'b0);
		row(1'b0, CH_BSLASH, 1'b1, 1'b0);
		row(1'b0, CH_RBRACK, 1'b1, 1'b0);
		row(1'b0, CH_RBRACK, 1'b1, 1'b0);
		row(1'b0, CH_LPAREN, 1'b1, 1'b0);
		row(1'b0, CH_LPAREN, 1'b1, 1'b0);
		row(1'b0, CH_RPAREN, 1'b1, 1'b0);
		row(1'b0, 8'h80, 1'b1, 1'b0);
		row(1'b0, CH_RPAREN, 1'b1, 1'b0);
		row(1'b0, 8'h71, 1'b1, 1'b1);
		row(1'b0, CH_DQUOTE, 1'b1, 1'b0);
		row(1'b0, CH_BSLASH, 1'b1, 1'b1);
		row_typed(1'b1, CH_SLASH, 1'b1, 1'b0, TK_TSPECIAL, 0, 1);
		row(1'b1, CH_PERIOD, 1'b1, 1'b0);
		row(1'b1, CH_EQUALS, 1'b1, 1'b0);
		row(1'b1, 8'h6B, 1'b1, 1'b0);
		row(1'b1, CH_LPAREN, 1'b1, 1'b1);

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < directed.size(); i++) begin
			v = directed[i];
			if (v.mode !== mode_q) begin
				settle();
				write_mode(v.mode);
			end
			send_item(v.item, 1'b0);
			if (v.typed) begin
				repeat (last_count) void'(expected_tokens.pop_back());
				expected_tokens.push_back(v.tok);
			end
		end

		// Byte position saturates at the end of a very long field.
		for (int i = 0; i < POS_CAP - 2; i++)
			send_byte(pick_blank(), 1'b0, 1'b1);
		send_byte(8'h61, 1'b0, 1'b1);
		send_byte(8'h62, 1'b0, 1'b1);
		send_byte(CH_AT, 1'b0, 1'b1);
		send_byte(CH_DQUOTE, 1'b0, 1'b1);
		send_byte(8'h78, 1'b1, 1'b1);

		// A quoted string longer than the length field can hold.
		send_byte(CH_DQUOTE, 1'b0, 1'b1);
		for (int i = 0; i < POS_CAP + 4; i++)
			send_byte(8'h79, 1'b0, 1'b1);
		send_byte(CH_DQUOTE, 1'b1, 1'b1);

		// Comment nesting deeper than the depth counter, closed early.
		repeat (DEPTH_CAP + 45) send_byte(CH_LPAREN, 1'b0, 1'b0);
		repeat (DEPTH_CAP) send_byte(CH_RPAREN, 1'b0, 1'b0);
		send_byte(CH_RPAREN, 1'b0, 1'b0);
		it.data_byte = 8'h00;
		it.byte_valid = 1'b0;
		it.end_of_field = 1'b1;
		send_item(it, 1'b0);

		items_sent = 0;
		for (int f = 0; items_sent < RANDOM_ITEMS; f++) begin
			if (f % 4 == 0) begin
				settle();
				write_mode(1'((f / 4) % 2));
			end
			build_field();
			send_field();
		end

		settle();
		repeat (10) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			report("token never arrived", expected_tokens[0]);
			mismatches += expected_tokens.size() - 1;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
